>>> sv/fsm_transition_hash_table_defines.svh
// Assertion macros for the transition hash table.
// Used by the top level only; depends on nothing else.
`ifndef FSM_TRANSITION_HASH_TABLE_DEFINES_SVH
`define FSM_TRANSITION_HASH_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FTH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fth_pkg.sv
// Package for the transition hash table: widths, types, sequencer states.
// Used by every module of the block.
package fth_pkg;

    localparam int MaxBuckets   = 16;
    localparam int NodeCapacity = 256;
    localparam int KeyW         = 31;
    localparam int StateW       = 10;
    localparam int NodeW        = $clog2(NodeCapacity);
    localparam int BucketW      = $clog2(MaxBuckets);
    localparam int LinkW        = NodeW + 1;
    localparam int UsedW        = NodeW + 1;
    localparam int CountW       = 5;
    localparam int ResultW      = 11;
    localparam int RemW         = CountW;

    localparam logic [LinkW-1:0]   NullLink    = {LinkW{1'b1}};
    localparam logic [CountW-1:0]  CountReset  = CountW'(11);
    localparam logic [ResultW-1:0] ResultMiss  = {ResultW{1'b1}};
    localparam logic [7:0]         AddrBucket  = 8'h00;

    localparam logic FuncLookup = 1'b0;
    localparam logic FuncInsert = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_HEAD,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_OUT
    } seq_state_t;

    // Control from the sequencer to the remainder unit.
    typedef struct packed {
        logic             start;
        logic [KeyW-1:0]  key;
        logic [CountW-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [RemW-1:0]  rem;
    } mod_rsp_t;

endpackage

>>> sv/fth_mod_unit.sv
// Bit-serial remainder unit: key mod divisor, one key bit per cycle.
// Depends on fth_pkg.
module fth_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  fth_pkg::mod_req_t req,
    output fth_pkg::mod_rsp_t rsp
);
    import fth_pkg::*;

    localparam int CntW = $clog2(KeyW + 1);

    logic              busy_reg, busy_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [KeyW-1:0]   key_reg, key_next;
    logic [RemW-1:0]   rem_reg, rem_next;
    logic [CountW-1:0] div_reg, div_next;
    logic              done_reg, done_next;
    logic [RemW:0]     shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, key_reg[KeyW-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(KeyW);
            key_next  = req.key;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so one compare and subtract
            if (shifted >= {1'b0, div_reg})
                rem_next = RemW'(shifted - {1'b0, div_reg});
            else
                rem_next = RemW'(shifted);
            key_next = {key_reg[KeyW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> sv/fth_node_ram.sv
// Node pool memory: key, state and link of each node, one port.
// Depends on fth_pkg.
module fth_node_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [fth_pkg::NodeW-1:0]  addr,
    input  logic [fth_pkg::KeyW-1:0]   wkey,
    input  logic [fth_pkg::StateW-1:0] wstate,
    input  logic [fth_pkg::LinkW-1:0]  wlink,
    output logic [fth_pkg::KeyW-1:0]   rkey,
    output logic [fth_pkg::StateW-1:0] rstate,
    output logic [fth_pkg::LinkW-1:0]  rlink
);
    import fth_pkg::*;

    logic [KeyW+StateW+LinkW-1:0] mem [NodeCapacity];
    logic [KeyW+StateW+LinkW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= {wkey, wstate, wlink};
        rd_reg <= mem[addr];
    end

    assign rkey   = rd_reg[KeyW+StateW+LinkW-1:StateW+LinkW];
    assign rstate = rd_reg[StateW+LinkW-1:LinkW];
    assign rlink  = rd_reg[LinkW-1:0];

endmodule

>>> sv/fsm_transition_hash_table.sv
// Top level of the transition hash table: APB register, stream ports, sequencer.
// Depends on fth_pkg, fth_mod_unit, fth_node_ram and the assertion header.
//
// One word is taken at a time. The bucket is found by a bit-serial remainder
// unit, one key bit per cycle. The chain is then walked through a single-port
// node memory, with a read state and a compare state per node. An update of a
// key already present passes through a further write state; a new key is
// written during the last chain read. The next word can be taken in the cycle
// after the result is loaded. The result is held in an output register until
// taken. The bucket count should change only while the table is empty.
// There is no clearing pass: bucket heads reset in flops.
`include "fsm_transition_hash_table_defines.svh"

module fsm_transition_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[0], object_id[11:1], current_state[21:12], event_input[31:22],
    // new_state[41:32], zero[47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_state[10:0], hit[11], table_full[12], zero[15:13]
    output logic [15:0] m_tdata
);
    import fth_pkg::*;

    seq_state_t state_reg, state_next;
    logic [CountW-1:0]  count_reg;
    logic [LinkW-1:0]   heads_reg [MaxBuckets];
    logic [UsedW-1:0]   used_reg, used_next;
    logic               func_reg;
    logic [KeyW-1:0]    key_reg;
    logic [StateW-1:0]  nst_reg;
    logic [BucketW-1:0] bkt_reg, bkt_next;
    logic [LinkW-1:0]   cur_reg, cur_next;
    logic [ResultW-1:0] res_reg, res_next;
    logic               hit_reg, hit_next, full_reg, full_next;
    logic               ovalid_reg, ovalid_next;

    logic [CountW-1:0]  eff_count;
    mod_req_t           mreq;
    mod_rsp_t           mrsp;
    logic               we, head_we;
    logic [NodeW-1:0]   addr;
    logic [KeyW-1:0]    wkey, rkey;
    logic [StateW-1:0]  wstate, rstate;
    logic [LinkW-1:0]   wlink, rlink;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == AddrBucket[1:0]) ? {27'd0, count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CountReset;
        else if (cfg_wr && paddr == AddrBucket[1:0])
            count_reg <= pwdata[CountW-1:0];
    end

    always_comb
    begin
        eff_count = count_reg;
        if (count_reg == '0)
            eff_count = CountW'(1);
        else if (count_reg > CountW'(MaxBuckets))
            eff_count = CountW'(MaxBuckets);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign mreq.start   = s_tvalid && s_tready;
    assign mreq.key     = {s_tdata[11:1], s_tdata[21:12], s_tdata[31:22]};
    assign mreq.divisor = eff_count;

    fth_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    fth_node_ram u_ram (
        .clk    (clk),
        .we     (we),
        .addr   (addr),
        .wkey   (wkey),
        .wstate (wstate),
        .wlink  (wlink),
        .rkey   (rkey),
        .rstate (rstate),
        .rlink  (rlink)
    );

    always_comb
    begin
        state_next  = state_reg;
        bkt_next    = bkt_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        hit_next    = hit_reg;
        full_next   = full_reg;
        used_next   = used_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        head_we     = 1'b0;
        addr        = cur_reg[NodeW-1:0];
        wkey        = key_reg;
        wstate      = nst_reg;
        wlink       = cur_reg;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (mreq.start)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mrsp.done)
                begin
                    bkt_next   = mrsp.rem[BucketW-1:0];
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cur_next   = heads_reg[bkt_reg];
                state_next = ST_READ;
            end
            ST_READ:
            begin
                // null link ends the walk as a miss
                if (cur_reg == NullLink)
                begin
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    if (func_reg == FuncLookup)
                    begin
                        res_next   = ResultMiss;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        res_next = '0;
                        if (used_reg == UsedW'(NodeCapacity))
                        begin
                            full_next  = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            // prepend new node: link to the old head
                            we         = 1'b1;
                            addr       = used_reg[NodeW-1:0];
                            wlink      = heads_reg[bkt_reg];
                            head_we    = 1'b1;
                            used_next  = used_reg + 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                end
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rkey == key_reg)
                begin
                    res_next  = {1'b0, rstate};
                    hit_next  = 1'b1;
                    full_next = 1'b0;
                    state_next = (func_reg == FuncInsert) ? ST_WRITE : ST_OUT;
                end
                else
                begin
                    cur_next   = rlink;
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                we         = 1'b1;
                wkey       = rkey;
                wlink      = rlink;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < MaxBuckets; i++)
                heads_reg[i] <= NullLink;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            ovalid_reg <= ovalid_next;
            if (head_we)
                heads_reg[bkt_reg] <= {1'b0, used_reg[NodeW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.start)
        begin
            func_reg <= s_tdata[0];
            key_reg  <= mreq.key;
            nst_reg  <= s_tdata[41:32];
        end
        bkt_reg  <= bkt_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
    end

    // output register keeps its word while the walk is idle
    logic [ResultW-1:0] ores_reg;
    logic               ohit_reg, ofull_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!ovalid_reg || m_tready))
        begin
            ores_reg  <= res_reg;
            ohit_reg  <= hit_reg;
            ofull_reg <= full_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'd0, ofull_reg, ohit_reg, ores_reg};

    `FTH_ASSERT_IMP(a_ready_idle, s_tready, state_reg == ST_IDLE, "ready outside idle")
    `FTH_ASSERT_IMP(a_used_cap, 1'b1, used_reg <= UsedW'(NodeCapacity), "pool overrun")
    `FTH_ASSERT_IMP(a_full_miss, m_tvalid && m_tdata[12], !m_tdata[11], "full with hit")
    `FTH_ASSERT_NXT(a_start_mod, s_tvalid && s_tready, state_reg == ST_MOD, "no mod after accept")

endmodule
